// ----- design/sse_pkg.sv -----
// Package for the sorted set engine: opcodes, status codes, FSM states.
// No dependencies; imported by sorted_set_engine_core.
package sse_pkg;

    localparam int MAX_RESULTS = 32;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_INTERSECT = 2'd1,
        OP_UNION     = 2'd2,
        OP_SYMDIFF   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_MEMBER    = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_INSERTED  = 3'd2,
        STAT_DUPLICATE = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_REPLY,
        S_MERGE
    } state_t;

    // How members of the source set are filtered against the other set
    typedef enum logic [1:0] {
        MODE_ALL,
        MODE_IN,
        MODE_OUT
    } mode_t;

    function automatic mode_t merge_mode(input op_t op, input logic pass);
        mode_t m;
        m = MODE_OUT;
        unique case (op)
            OP_INTERSECT: m = MODE_IN;
            OP_UNION:     m = pass ? MODE_OUT : MODE_ALL;
            default:      m = MODE_OUT;
        endcase
        return m;
    endfunction

endpackage

// ----- design/sse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for both member stores of the sorted set engine.
module sse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/sorted_set_engine_core.sv -----
// Sorted set engine top level: FSM, merge datapath and output register.
// Depends on sse_pkg and sse_ram (one RAM per set).
//
// Usage:
//   Input channel s_* carries one command per transaction: insert a value
//   into set A or B, or a query (intersect, union, symmetric difference).
//   Result channel m_* returns the answer; m_last marks the final result
//   transaction of a command. Inserts give one result with a status code;
//   queries give one member per transaction (at most 32), or one empty
//   marker when the answer is empty.
// Timing:
//   Commands are handled one at a time; s_ready is high only when the
//   engine is idle, but a finished result may still sit in the output
//   register. An insert runs an ordered scan, then moves one entry per
//   cycle (limited by the single RAM port pair). A query walks both sets
//   in a merge, one RAM read per set per cycle while the output is not
//   stalled; two passes for union and difference.
// Reset: both sets become empty; store contents are not cleared.
// Stall: while m_ready is low and a result is waiting, the merge freezes
//   at the next member to report; nothing is dropped.
module sorted_set_engine_core
    import sse_pkg::*;
#(
    parameter int SET_DEPTH   = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic               s_set_select,
    input  logic signed [15:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_result_value,
    output logic [2:0]         m_status,
    output logic               m_last
);

    localparam int AW  = $clog2(SET_DEPTH);
    localparam int CW  = $clog2(SET_DEPTH + 1);
    localparam int OCW = $clog2(MAX_RESULTS);

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic                   set_reg, set_next;
    logic                   pass_reg, pass_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] v_reg, v_next;
    status_t                status_reg, status_next;
    logic [CW-1:0]          count_reg [2];
    logic [CW-1:0]          count_next [2];
    logic                   hold_valid_reg, hold_valid_next;
    logic [15:0]            hold_value_reg, hold_value_next;
    logic [OCW-1:0]         out_cnt_reg, out_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [15:0]            m_value_reg, m_value_next;
    logic [2:0]             m_status_reg, m_status_next;
    logic                   m_last_reg, m_last_next;

    // memory ports
    logic [VALUE_WIDTH-1:0] rd0, rd1, wdata;
    logic [AW-1:0]          waddr, raddr0, raddr1;
    logic [CW-1:0]          ridx0, ridx1;
    logic                   wen, we0, we1;

    // datapath decisions
    logic [VALUE_WIDTH-1:0] src_data, oth_data;
    logic [CW-1:0]          cnt_src, cnt_oth;
    logic                   src_done, oth_done, src_lt, src_eq;
    logic                   keep, adv_i, adv_j, merge_stall, cap_hit, has_pass2;
    logic                   scan_hit, dup, full, out_free, accept;
    mode_t                  mode;
    logic [31:0]            in_ext, src_ext;
    logic [15:0]            src_out;

    logic                   push_en, push_last;
    logic [15:0]            push_value;
    status_t                push_status;

    sse_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(SET_DEPTH)) u_ram_a (
        .clk(aclk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr0), .rdata(rd0)
    );

    sse_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(SET_DEPTH)) u_ram_b (
        .clk(aclk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr1), .rdata(rd1)
    );

    // read address follows the next index so data lines up with the index register
    assign ridx0  = set_next ? j_next : i_next;
    assign ridx1  = set_next ? i_next : j_next;
    assign raddr0 = ridx0[AW-1:0];
    assign raddr1 = ridx1[AW-1:0];
    assign we0    = wen && !set_reg;
    assign we1    = wen && set_reg;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign in_ext  = 32'(s_value);
    assign src_ext = 32'($signed(src_data));
    assign src_out = src_ext[15:0];

    always_comb begin
        src_data  = set_reg ? rd1 : rd0;
        oth_data  = set_reg ? rd0 : rd1;
        cnt_src   = count_reg[set_reg];
        cnt_oth   = count_reg[!set_reg];
        src_done  = (i_reg == cnt_src);
        oth_done  = (j_reg == cnt_oth);
        src_lt    = $signed(src_data) < $signed(oth_data);
        src_eq    = (src_data == oth_data);
        mode      = merge_mode(op_reg, pass_reg);
        has_pass2 = (op_reg != OP_INTERSECT);
        cap_hit   = hold_valid_reg && (out_cnt_reg == OCW'(MAX_RESULTS - 1));

        keep  = 1'b0;
        adv_i = 1'b0;
        adv_j = 1'b0;
        if (mode == MODE_ALL) begin
            keep  = 1'b1;
            adv_i = 1'b1;
        end else if (oth_done || src_lt) begin
            keep  = (mode == MODE_OUT);
            adv_i = 1'b1;
        end else if (src_eq) begin
            keep  = (mode == MODE_IN);
            adv_i = 1'b1;
            adv_j = 1'b1;
        end else begin
            adv_j = 1'b1;
        end
        merge_stall = keep && hold_valid_reg && !out_free;

        scan_hit = src_done || !($signed(src_data) < $signed(v_reg));
        dup      = !src_done && (src_data == v_reg);
        full     = (cnt_src == CW'(SET_DEPTH));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (op_t'(s_operation) == OP_INSERT) ? S_SCAN : S_MERGE;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    if (dup || full) begin
                        state_next = S_REPLY;
                    end else if (src_done) begin
                        state_next = S_PLACE;
                    end else begin
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (i_reg == pos_reg) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: state_next = S_REPLY;
            S_REPLY: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_MERGE: begin
                if (src_done) begin
                    if (!(!pass_reg && has_pass2) && out_free) begin
                        state_next = S_IDLE;
                    end
                end else if (!merge_stall && keep && cap_hit) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and output pushes
    always_comb begin
        op_next         = op_reg;
        set_next        = set_reg;
        pass_next       = pass_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        pos_next        = pos_reg;
        v_next          = v_reg;
        status_next     = status_reg;
        count_next[0]   = count_reg[0];
        count_next[1]   = count_reg[1];
        hold_valid_next = hold_valid_reg;
        hold_value_next = hold_value_reg;
        out_cnt_next    = out_cnt_reg;
        wen             = 1'b0;
        waddr           = '0;
        wdata           = v_reg;
        push_en         = 1'b0;
        push_last       = 1'b1;
        push_value      = '0;
        push_status     = status_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next         = op_t'(s_operation);
                    set_next        = (op_t'(s_operation) == OP_INSERT) ? s_set_select : 1'b0;
                    pass_next       = 1'b0;
                    i_next          = '0;
                    j_next          = '0;
                    v_next          = in_ext[VALUE_WIDTH-1:0];
                    hold_valid_next = 1'b0;
                    out_cnt_next    = '0;
                end
            end
            S_SCAN: begin
                if (!scan_hit) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    pos_next = i_reg;
                    if (dup) begin
                        status_next = STAT_DUPLICATE;
                    end else if (full) begin
                        status_next = STAT_FULL;
                    end else if (!src_done) begin
                        i_next = cnt_src - 1'b1;  // shift starts at the top member
                    end
                end
            end
            S_SHIFT: begin
                wen   = 1'b1;
                waddr = AW'(i_reg + 1'b1);
                wdata = src_data;
                if (i_reg != pos_reg) begin
                    i_next = i_reg - 1'b1;
                end
            end
            S_PLACE: begin
                wen                 = 1'b1;
                waddr               = pos_reg[AW-1:0];
                wdata               = v_reg;
                count_next[set_reg] = cnt_src + 1'b1;
                status_next         = STAT_INSERTED;
            end
            S_REPLY: begin
                push_en     = out_free;
                push_status = status_reg;
            end
            S_MERGE: begin
                if (src_done) begin
                    if (!pass_reg && has_pass2) begin
                        pass_next = 1'b1;
                        set_next  = 1'b1;
                        i_next    = '0;
                        j_next    = '0;
                    end else if (out_free) begin
                        push_en         = 1'b1;
                        push_value      = hold_valid_reg ? hold_value_reg : 16'd0;
                        push_status     = hold_valid_reg ? STAT_MEMBER : STAT_EMPTY;
                        hold_valid_next = 1'b0;
                    end
                end else if (!merge_stall) begin
                    if (adv_i) begin
                        i_next = i_reg + 1'b1;
                    end
                    if (adv_j) begin
                        j_next = j_reg + 1'b1;
                    end
                    if (keep) begin
                        // one member is held back so the final one can carry last
                        if (hold_valid_reg) begin
                            push_en      = 1'b1;
                            push_value   = hold_value_reg;
                            push_status  = STAT_MEMBER;
                            push_last    = cap_hit;
                            out_cnt_next = out_cnt_reg + 1'b1;
                            if (cap_hit) begin
                                hold_valid_next = 1'b0;
                            end else begin
                                hold_value_next = src_out;
                            end
                        end else begin
                            hold_valid_next = 1'b1;
                            hold_value_next = src_out;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next  = push_en ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_value_next  = push_en ? push_value : m_value_reg;
        m_status_next = push_en ? push_status : m_status_reg;
        m_last_next   = push_en ? push_last : m_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg[0]   <= '0;
            count_reg[1]   <= '0;
            hold_valid_reg <= 1'b0;
            out_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg[0]   <= count_next[0];
            count_reg[1]   <= count_next[1];
            hold_valid_reg <= hold_valid_next;
            out_cnt_reg    <= out_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        set_reg        <= set_next;
        pass_reg       <= pass_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        pos_reg        <= pos_next;
        v_reg          <= v_next;
        status_reg     <= status_next;
        hold_value_reg <= hold_value_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_status       = m_status_reg;
    assign m_last         = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg[0] <= CW'(SET_DEPTH)) && (count_reg[1] <= CW'(SET_DEPTH)))
        else $error("set count beyond depth");

    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (we0 || we1) |-> (state_reg == S_SHIFT || state_reg == S_PLACE))
        else $error("store written outside an insert");

    a_hold_in_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> (state_reg == S_MERGE))
        else $error("held member outside a query");

    a_merge_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MERGE) |-> (i_reg <= cnt_src && j_reg <= cnt_oth))
        else $error("merge index ran past set count");

    a_place_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PLACE) |=>
            (count_reg[set_reg] == $past(count_reg[set_reg]) + 1'b1))
        else $error("insert did not grow the set");

endmodule
